/* hdl/bpl_pkg.sv */
`default_nettype none
package bpl_pkg;
  localparam int POINTS = 256;
  localparam int IDX_W = 8;
  localparam int LEN_W = 9;

  localparam logic [2:0] REG_POINTS = 3'd0;
  localparam logic [2:0] REG_LINEAR = 3'd1;
  localparam logic [2:0] REG_ACCUM  = 3'd2;
  localparam logic [2:0] REG_WRAP   = 3'd3;
  localparam logic [2:0] REG_NORM   = 3'd4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

/* hdl/bpl_div.sv */
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module bpl_div import bpl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;
endmodule
`default_nettype wire

/* hdl/breakpoint_phase_lookup.sv */
`default_nettype none
// Breakpoint table lookup with piecewise linear interpolation. A write item
// (tuser = 0) stores one point in the cycle of its transfer. A lookup item
// (tuser = 1) is handled by a sequencer: an optional wrap through a bit-serial
// divider, a walk of one table read per step from the kept segment index, a
// second divide for the relative position and a multiply for the value. A
// lookup that lands before the first point, on the last point or on a segment
// of zero or negative width skips the second divide. A repeated phase with
// nothing changed and accumulation off, or an empty table, is answered right
// after the accepting edge. The block accepts no item while a lookup is in
// progress or a result waits. Table slots never written read as unknown
// values.
module breakpoint_phase_lookup import bpl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [103:0] s_tdata, // point_index, point_x, point_y, phase
  input  wire logic        s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata   // value, position, segment, seg_width
);
  localparam logic [3:0] ST_IDLE = 4'd0, ST_WRAP = 4'd1, ST_WRAPW = 4'd2,
    ST_SAT = 4'd3, ST_RD = 4'd4, ST_CMP = 4'd5, ST_RDX1 = 4'd6, ST_REL = 4'd7,
    ST_RELW = 4'd8, ST_RY = 4'd9, ST_MUL = 4'd10, ST_FIN = 4'd11,
    ST_OUT = 4'd12;

  logic [3:0] state;
  logic [31:0] x_mem [POINTS];
  logic [31:0] y_mem [POINTS];
  logic [IDX_W-1:0] rd_addr;
  logic signed [31:0] x_rd;
  logic signed [31:0] y_rd;

  logic [LEN_W-1:0] points_in_use;
  logic linear_mode, accumulate_phase, wrap_phase, normalized_x;
  logic table_dirty;
  logic [IDX_W-1:0] seg_index;
  logic signed [31:0] last_phase, acc_phase;
  logic signed [31:0] held_value, held_width;
  logic [16:0] held_rel;

  logic signed [31:0] raw;
  logic signed [63:0] pw;
  logic signed [31:0] p;
  logic [IDX_W-1:0] idx, last;
  logic dir_down, dir_set;
  logic signed [31:0] x0, x1, y0, y1;
  logic below;
  logic [16:0] rel;
  logic signed [63:0] prod;
  logic neg;

  logic [7:0] in_index;
  logic signed [31:0] in_x, in_y, smp_phase;
  assign in_index = s_tdata[7:0];
  assign in_x = s_tdata[39:8];
  assign in_y = s_tdata[71:40];
  assign smp_phase = s_tdata[103:72];

  div_req_t dreq;
  div_rsp_t drsp;
  bpl_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [LEN_W-1:0] len;
  assign len = (points_in_use > LEN_W'(POINTS)) ? LEN_W'(POINTS) : points_in_use;

  logic s_acc;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign s_acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == CMD_WRITE) begin
      x_mem[in_index] <= in_x;
      y_mem[in_index] <= in_y;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  logic [63:0] mod_val, pabs;
  assign mod_val = normalized_x ? 64'd65536 : {40'd0, last, 16'd0};
  assign pabs = pw[63] ? 64'(-pw) : 64'(pw);

  // The upper point arrives from the table in the cycle the divide starts.
  logic signed [63:0] relnum, relden;
  assign relnum = (64'(signed'(p)) - 64'(signed'(x0))) <<< 16;
  assign relden = 64'(signed'(x_rd)) - 64'(signed'(x0));

  logic signed [63:0] qv;
  assign qv = prod >>> 16;

  always_comb begin
    dreq = '0;
    if (state == ST_WRAP) begin
      dreq.start = 1'b1;
      dreq.dividend = pabs;
      dreq.divisor = mod_val;
    end else if (state == ST_REL) begin
      dreq.start = 1'b1;
      dreq.dividend = relnum[63] ? 64'(-relnum) : 64'(relnum);
      dreq.divisor = relden;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      points_in_use <= '0;
      linear_mode <= 1'b1;
      accumulate_phase <= 1'b0;
      wrap_phase <= 1'b0;
      normalized_x <= 1'b1;
      table_dirty <= 1'b1;
      seg_index <= '0;
      last_phase <= '0;
      acc_phase <= '0;
      held_value <= '0;
      held_rel <= '0;
      held_width <= '0;
      rd_addr <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINTS: begin points_in_use <= cfg_data; table_dirty <= 1'b1; end
          REG_LINEAR: begin linear_mode <= cfg_data[0]; table_dirty <= 1'b1; end
          REG_ACCUM:  begin accumulate_phase <= cfg_data[0]; table_dirty <= 1'b1; end
          REG_WRAP:   begin wrap_phase <= cfg_data[0]; table_dirty <= 1'b1; end
          REG_NORM:   begin normalized_x <= cfg_data[0]; table_dirty <= 1'b1; end
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser == CMD_WRITE) begin
              table_dirty <= 1'b1;
            end else if (len == '0) begin
              m_tdata <= '0;
              m_tvalid <= 1'b1;
            end else if (!table_dirty && !accumulate_phase && smp_phase == last_phase) begin
              m_tdata <= {7'd0, held_width, seg_index, held_rel, held_value};
              m_tvalid <= 1'b1;
            end else begin
              raw <= smp_phase;
              last <= IDX_W'(len - LEN_W'(1));
              pw <= accumulate_phase ? 64'(signed'(acc_phase)) + 64'(signed'(smp_phase))
                                     : 64'(signed'(smp_phase));
              state <= (wrap_phase && (normalized_x || len != LEN_W'(1))) ? ST_WRAP : ST_SAT;
            end
          end
        end
        ST_WRAP: state <= ST_WRAPW;
        ST_WRAPW: begin
          if (drsp.done) begin
            pw <= pw[63] ? -64'(signed'(drsp.remainder)) : 64'(signed'(drsp.remainder));
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          p <= sat32(pw);
          idx <= (seg_index < last) ? seg_index : last;
          rd_addr <= (seg_index < last) ? seg_index : last;
          dir_set <= 1'b0;
          state <= ST_RD;
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          // First read decides direction; later reads test the next point in that direction.
          if (!dir_set) begin
            dir_set <= 1'b1;
            dir_down <= p < x_rd;
            if (p < x_rd && idx != '0) begin
              idx <= idx - 1'b1; rd_addr <= idx - 1'b1; state <= ST_RD;
            end else if (!(p < x_rd) && idx != last) begin
              rd_addr <= idx + 1'b1; state <= ST_RD;
            end else begin
              rd_addr <= idx; state <= ST_RDX1;
            end
          end else if (dir_down) begin
            if (p < x_rd && idx != '0) begin
              idx <= idx - 1'b1; rd_addr <= idx - 1'b1; state <= ST_RD;
            end else begin
              rd_addr <= idx; state <= ST_RDX1;
            end
          end else begin
            if (p >= x_rd) begin
              idx <= idx + 1'b1;
              if (idx + 1'b1 != last) begin
                rd_addr <= idx + 2'd2; state <= ST_RD;
              end else begin
                rd_addr <= idx + 1'b1; state <= ST_RDX1;
              end
            end else begin
              rd_addr <= idx; state <= ST_RDX1;
            end
          end
        end
        ST_RDX1: begin
          rd_addr <= (idx < last) ? idx + 1'b1 : last;
          state <= ST_RY;
        end
        ST_RY: begin
          x0 <= x_rd; y0 <= y_rd;
          below <= p < x_rd;
          state <= ST_REL;
        end
        ST_REL: begin
          y1 <= y_rd;
          if (below || idx == last) begin
            x1 <= x0;
            rel <= below ? 17'd0 : 17'd65536;
            state <= ST_MUL;
          end else begin
            x1 <= x_rd;
            if (64'(signed'(x_rd)) - 64'(signed'(x0)) <= 0) begin
              rel <= 17'd0;
              state <= ST_MUL;
            end else begin
              neg <= p < x0;
              state <= ST_RELW;
            end
          end
        end
        ST_RELW: begin
          if (drsp.done) begin
            if (neg) rel <= 17'd0;
            else if (drsp.quotient > 64'd65536) rel <= 17'd65536;
            else rel <= drsp.quotient[16:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= 64'(signed'({1'b0, rel})) * (64'(signed'(y1)) - 64'(signed'(y0)));
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (linear_mode) held_value <= sat32(64'(signed'(y0)) + qv);
          else held_value <= y0;
          held_rel <= rel;
          held_width <= sat32(64'(signed'(x1)) - 64'(signed'(x0)));
          seg_index <= idx;
          last_phase <= raw;
          acc_phase <= p;
          table_dirty <= 1'b0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          m_tdata <= {7'd0, held_width, seg_index, held_rel, held_value};
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accepted while busy");
  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> held_rel <= 17'd65536) else $error("rel out of range");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> idx <= last) else $error("segment past end");
`endif
endmodule
`default_nettype wire
